// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the vertex transform RTL.
// No dependencies; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define VTP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define VTP_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- rtl/vtp_pkg.sv -----
// Shared constants, types and saturation helper for the vertex transform.
// No dependencies.
package vtp_pkg;

   localparam int COORD_W   = 32;
   localparam int COEF_W    = 16;
   localparam int COEF_FRAC = 14;
   localparam int NUM_W     = 63;   // magnitude of coordinate times scale
   localparam int DEN_W     = 32;   // magnitude of camera z
   localparam int DIV_STEPS = NUM_W;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 64;
   localparam int WIDE_W    = 66;

   localparam logic [CSR_AW-1:0] REG_ROW_X   = 3'd0;
   localparam logic [CSR_AW-1:0] REG_ROW_Y   = 3'd1;
   localparam logic [CSR_AW-1:0] REG_ROW_Z   = 3'd2;
   localparam logic [CSR_AW-1:0] REG_TRANS_XY = 3'd3;
   localparam logic [CSR_AW-1:0] REG_TRANS_Z = 3'd4;
   localparam logic [CSR_AW-1:0] REG_SCALES  = 3'd5;
   localparam logic [CSR_AW-1:0] REG_OFFSETS = 3'd6;
   localparam logic [CSR_AW-1:0] REG_ASPECT  = 3'd7;

   // Sideband that rides along the divider stages
   typedef struct packed {
      logic                      valid;
      logic                      last;
      logic                      fault;
      logic                      neg_x;
      logic                      neg_y;
      logic signed [COORD_W-1:0] depth;
   } sb_type;

   // Clamp a wide signed value to the coordinate range
   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = (WIDE_W'(1) <<< (COORD_W-1)) - WIDE_W'(1);
      lo = -hi - WIDE_W'(1);
      if (v > hi) return hi[COORD_W-1:0];
      else if (v < lo) return lo[COORD_W-1:0];
      else return v[COORD_W-1:0];
   endfunction

endpackage

// ----- rtl/vtp_div.sv -----
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on vtp_pkg.
module vtp_div (
   input  logic                        clock,
   input  logic                        en,
   input  logic [vtp_pkg::NUM_W-1:0]   num,
   input  logic [vtp_pkg::DEN_W-1:0]   den,
   output logic [vtp_pkg::NUM_W-1:0]   quo
);
   import vtp_pkg::*;

   logic [NUM_W-1:0] num_ff [DIV_STEPS];
   logic [NUM_W-1:0] quo_ff [DIV_STEPS];
   logic [DEN_W-1:0] den_ff [DIV_STEPS];
   logic [DEN_W-1:0] rem_ff [DIV_STEPS];

   for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
      logic [NUM_W-1:0] num_p;
      logic [NUM_W-1:0] quo_p;
      logic [DEN_W-1:0] den_p;
      logic [DEN_W-1:0] rem_p;
      logic [DEN_W:0]   rem_sh;
      logic [DEN_W:0]   diff;

      if (s == 0) begin : g_first
         assign num_p = num;
         assign quo_p = '0;
         assign den_p = den;
         assign rem_p = '0;
      end else begin : g_next
         assign num_p = num_ff[s-1];
         assign quo_p = quo_ff[s-1];
         assign den_p = den_ff[s-1];
         assign rem_p = rem_ff[s-1];
      end

      // Bring down the next dividend bit and trial-subtract
      assign rem_sh = {rem_p, num_p[NUM_W-1]};
      assign diff   = rem_sh - {1'b0, den_p};

      always_ff @(posedge clock) begin
         if (en) begin
            num_ff[s] <= num_p << 1;
            den_ff[s] <= den_p;
            quo_ff[s] <= {quo_p[NUM_W-2:0], ~diff[DEN_W]};
            rem_ff[s] <= diff[DEN_W] ? rem_sh[DEN_W-1:0] : diff[DEN_W-1:0];
         end
      end
   end

   assign quo = quo_ff[DIV_STEPS-1];

endmodule

// ----- rtl/vertex_transform_project.sv -----
// Vertex transform and perspective projection, top level.
// Depends on vtp_pkg, vtp_div and assert_macros.svh.
//
// Usage:
//   req_* carries one model vertex per beat (x, y, z in tdata, mesh end in
//   tlast). rsp_* returns one projected vertex per beat (screen x, screen y,
//   depth, divide fault in tdata, tlast copied from the request).
//   csr_* writes the matrix, translation, projection and aspect registers;
//   write only while no vertex is in flight.
// Timing:
//   Five arithmetic stages (products, row sums, aspect product, aspect
//   round, projection products), 63 divider stages at one quotient bit each,
//   and the output register. One vertex is accepted every cycle while the
//   output is taken.
// Reset:
//   Clears all valid bits and loads the identity matrix, zero translation,
//   zero scales and offsets and an aspect of about 1.3333.
// Stall:
//   While rsp_tvalid is high and rsp_tready low the whole pipeline holds;
//   req_tready drops and no beat is lost or repeated.
module vertex_transform_project (
   input  logic                        clock,
   input  logic                        reset,
   // req_tdata: vertex_x, vertex_y, vertex_z
   input  logic [95:0]                 req_tdata,
   input  logic                        req_tlast,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // rsp_tdata: screen_x, screen_y, depth, divide_fault, zero pad
   output logic [103:0]                rsp_tdata,
   output logic                        rsp_tlast,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic                        csr_we,
   input  logic [vtp_pkg::CSR_AW-1:0]  csr_addr,
   input  logic [vtp_pkg::CSR_DW-1:0]  csr_wdata
);
   import vtp_pkg::*;

   // Configuration registers
   logic [3*COEF_W-1:0]        row_ff [3];
   logic [2*COORD_W-1:0]       trans_xy_ff;
   logic signed [COORD_W-1:0]  trans_z_ff;
   logic [2*COORD_W-1:0]       scales_ff;
   logic [2*COORD_W-1:0]       offsets_ff;
   logic signed [COEF_W-1:0]   aspect_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0]   <= 48'(1) << COEF_FRAC;
         row_ff[1]   <= 48'(1) << (COEF_FRAC + COEF_W);
         row_ff[2]   <= 48'(1) << (COEF_FRAC + 2*COEF_W);
         trans_xy_ff <= '0;
         trans_z_ff  <= '0;
         scales_ff   <= '0;
         offsets_ff  <= '0;
         aspect_ff   <= 16'sd21845;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_ROW_X:    row_ff[0]   <= csr_wdata[3*COEF_W-1:0];
            REG_ROW_Y:    row_ff[1]   <= csr_wdata[3*COEF_W-1:0];
            REG_ROW_Z:    row_ff[2]   <= csr_wdata[3*COEF_W-1:0];
            REG_TRANS_XY: trans_xy_ff <= csr_wdata;
            REG_TRANS_Z:  trans_z_ff  <= csr_wdata[COORD_W-1:0];
            REG_SCALES:   scales_ff   <= csr_wdata;
            REG_OFFSETS:  offsets_ff  <= csr_wdata;
            REG_ASPECT:   aspect_ff   <= csr_wdata[COEF_W-1:0];
            default: ;
         endcase
      end
   end

   // Whole pipeline moves when the output register is free or taken
   logic adv;
   logic rsp_valid_ff;
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   // Stage 1: nine coefficient products, z negated
   logic signed [COORD_W:0]   vin [3];
   logic signed [COORD_W+COEF_W:0] p1_ff [3][3];
   logic v1_ff, l1_ff;

   assign vin[0] = {req_tdata[31], req_tdata[31:0]};
   assign vin[1] = {req_tdata[63], req_tdata[63:32]};
   assign vin[2] = -{req_tdata[95], req_tdata[95:64]};

   always_ff @(posedge clock) begin
      if (adv) begin
         l1_ff <= req_tlast;
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
               p1_ff[r][k] <= $signed(row_ff[r][k*COEF_W +: COEF_W]) * vin[k];
            end
         end
      end
   end

   // Stage 2: row sums, round, translate, saturate
   logic signed [WIDE_W-1:0]  acc2 [3];
   logic signed [WIDE_W-1:0]  trn2 [3];
   logic signed [COORD_W-1:0] cam2_ff [3];
   logic v2_ff, l2_ff;

   assign trn2[0] = WIDE_W'($signed(trans_xy_ff[31:0]));
   assign trn2[1] = WIDE_W'($signed(trans_xy_ff[63:32]));
   assign trn2[2] = WIDE_W'(trans_z_ff);

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         acc2[r] = WIDE_W'(p1_ff[r][0]) + WIDE_W'(p1_ff[r][1]) + WIDE_W'(p1_ff[r][2])
                 + (WIDE_W'(1) <<< (COEF_FRAC-1));
         acc2[r] = (acc2[r] >>> COEF_FRAC) + trn2[r];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         l2_ff <= l1_ff;
         for (int r = 0; r < 3; r++) cam2_ff[r] <= sat_coord(acc2[r]);
      end
   end

   // Stage 3: aspect product on camera y
   logic signed [COORD_W+COEF_W-1:0] py3_ff;
   logic signed [COORD_W-1:0]        cx3_ff, cz3_ff;
   logic v3_ff, l3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         l3_ff  <= l2_ff;
         cx3_ff <= cam2_ff[0];
         cz3_ff <= cam2_ff[2];
         py3_ff <= cam2_ff[1] * aspect_ff;
      end
   end

   // Stage 4: round and saturate camera y, flag zero depth
   logic signed [WIDE_W-1:0]  ry4;
   logic signed [COORD_W-1:0] cx4_ff, cy4_ff, cz4_ff;
   logic v4_ff, l4_ff, f4_ff;

   assign ry4 = (WIDE_W'(py3_ff) + (WIDE_W'(1) <<< (COEF_FRAC-1))) >>> COEF_FRAC;

   always_ff @(posedge clock) begin
      if (adv) begin
         l4_ff  <= l3_ff;
         cx4_ff <= cx3_ff;
         cy4_ff <= sat_coord(ry4);
         cz4_ff <= cz3_ff;
         f4_ff  <= (cz3_ff == '0);
      end
   end

   // Stage 5: scale products
   logic signed [2*COORD_W-1:0] prx5_ff, pry5_ff;
   logic signed [COORD_W-1:0]   cz5_ff;
   logic v5_ff, l5_ff, f5_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         l5_ff   <= l4_ff;
         f5_ff   <= f4_ff;
         cz5_ff  <= cz4_ff;
         prx5_ff <= cx4_ff * $signed(scales_ff[31:0]);
         pry5_ff <= cy4_ff * $signed(scales_ff[63:32]);
      end
   end

   // Valid bits of the arithmetic stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // Magnitudes into the dividers, quotient signs ride alongside
   logic [2*COORD_W-1:0] absx, absy;
   logic [DEN_W-1:0]     absz;
   logic [NUM_W-1:0]     quox, quoy;

   assign absx = prx5_ff[2*COORD_W-1] ? 64'(-prx5_ff) : 64'(prx5_ff);
   assign absy = pry5_ff[2*COORD_W-1] ? 64'(-pry5_ff) : 64'(pry5_ff);
   assign absz = cz5_ff[COORD_W-1] ? DEN_W'(-cz5_ff) : DEN_W'(cz5_ff);

   vtp_div u_div_x (
      .clock (clock), .en (adv), .num (absx[NUM_W-1:0]), .den (absz), .quo (quox)
   );
   vtp_div u_div_y (
      .clock (clock), .en (adv), .num (absy[NUM_W-1:0]), .den (absz), .quo (quoy)
   );

   sb_type sb_ff [DIV_STEPS];
   sb_type sb_in;

   assign sb_in = '{valid: v5_ff, last: l5_ff, fault: f5_ff,
                    neg_x: prx5_ff[2*COORD_W-1] ^ cz5_ff[COORD_W-1],
                    neg_y: pry5_ff[2*COORD_W-1] ^ cz5_ff[COORD_W-1],
                    depth: cz5_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DIV_STEPS; s++) sb_ff[s].valid <= 1'b0;
      end else if (adv) begin
         sb_ff[0] <= sb_in;
         for (int s = 1; s < DIV_STEPS; s++) sb_ff[s] <= sb_ff[s-1];
      end
   end

   // Output stage: restore sign, add offset, saturate, zero screen coordinates on fault
   sb_type                     sbo;
   logic signed [WIDE_W-1:0]   qx, qy;
   logic signed [COORD_W-1:0]  sx, sy;
   logic [103:0]               rsp_data_ff;
   logic                       rsp_last_ff;

   assign sbo = sb_ff[DIV_STEPS-1];
   assign qx  = sbo.neg_x ? -WIDE_W'(quox) : WIDE_W'(quox);
   assign qy  = sbo.neg_y ? -WIDE_W'(quoy) : WIDE_W'(quoy);
   assign sx  = sbo.fault ? '0 : sat_coord(qx + WIDE_W'($signed(offsets_ff[31:0])));
   assign sy  = sbo.fault ? '0 : sat_coord(qy + WIDE_W'($signed(offsets_ff[63:32])));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= sbo.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= {7'd0, sbo.fault, sbo.depth, sy, sx};
         rsp_last_ff <= sbo.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Checks
   `include "assert_macros.svh"

   `VTP_ASSERT(a_fault_zero, rsp_tvalid && rsp_tdata[96] |-> rsp_tdata[63:0] == 64'd0, "fault beat with nonzero screen coordinates")
   `VTP_ASSERT(a_fault_depth, rsp_tvalid |-> rsp_tdata[96] == (rsp_tdata[95:64] == 32'd0), "fault flag disagrees with depth")
   `VTP_ASSERT(a_ready_link, req_tready == (!rsp_tvalid || rsp_tready), "input ready not tied to output stall")
   `VTP_ASSERT_ALWAYS(a_reset_idle, $past(reset) |-> !rsp_tvalid, "result beat right after reset")

endmodule

// ----- tb/vtp_checker.sv -----
// Checker for the vertex transform block: mirrors the register file, predicts each
// projected vertex and compares it against the response channel.
// Depends on vtp_pkg for the register indexes and widths.
`timescale 1ns / 1ps

module vtp_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [95:0]                 req_tdata,
   input  logic                        req_tlast,
   input  logic                        req_tvalid,
   input  logic                        req_tready,
   input  logic [103:0]                rsp_tdata,
   input  logic                        rsp_tlast,
   input  logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic                        csr_we,
   input  logic [vtp_pkg::CSR_AW-1:0]  csr_addr,
   input  logic [vtp_pkg::CSR_DW-1:0]  csr_wdata,
   output int                          mismatch_count,
   output int                          pending_count
);
   import vtp_pkg::*;

   typedef struct packed {
      logic [31:0] screen_x;
      logic [31:0] screen_y;
      logic [31:0] depth;
      logic        fault;
      logic        last;
   } projected_type;

   // Shadow copy of the camera registers
   logic [47:0] row_x, row_y, row_z;
   logic [63:0] trans_xy, scales, offsets;
   logic [31:0] trans_z;
   logic [15:0] aspect;

   projected_type projected_q[$];

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint coef(logic [47:0] r, int k);
      logic [15:0] c;
      c = r[k*16 +: 16];
      return longint'($signed(c));
   endfunction

   // Row dot product, round to Q16.16, add translation, clamp
   function automatic longint row_dot(logic [47:0] r, longint x, longint y, longint z,
                                      longint t);
      longint acc;
      acc = x * coef(r, 0) + y * coef(r, 1) + z * coef(r, 2);
      return clamp32(((acc + 64'sd8192) >>> COEF_FRAC) + t);
   endfunction

   function automatic longint perspective(longint c, longint z, logic [31:0] s,
                                          logic [31:0] o);
      longint q;
      q = (c * longint'($signed(s))) / z;
      return clamp32(q + longint'($signed(o)));
   endfunction

   function automatic projected_type project_vertex(logic [95:0] d, logic lst);
      projected_type p;
      longint vx, vy, vz, cx, cy, cz, sx, sy;
      vx = longint'($signed(d[31:0]));
      vy = longint'($signed(d[63:32]));
      vz = -longint'($signed(d[95:64]));
      cx = row_dot(row_x, vx, vy, vz, longint'($signed(trans_xy[31:0])));
      cy = row_dot(row_y, vx, vy, vz, longint'($signed(trans_xy[63:32])));
      cz = row_dot(row_z, vx, vy, vz, longint'($signed(trans_z)));
      cy = clamp32((cy * longint'($signed(aspect)) + 64'sd8192) >>> COEF_FRAC);
      sx = 0;
      sy = 0;
      if (cz != 0) begin
         sx = perspective(cx, cz, scales[31:0], offsets[31:0]);
         sy = perspective(cy, cz, scales[63:32], offsets[63:32]);
      end
      p.screen_x = sx[31:0];
      p.screen_y = sy[31:0];
      p.depth    = cz[31:0];
      p.fault    = (cz == 0);
      p.last     = lst;
      return p;
   endfunction

   always @(posedge clock) begin
      projected_type exp_p, got;
      if (reset) begin
         row_x    <= 48'd1 << COEF_FRAC;
         row_y    <= 48'd1 << (COEF_FRAC + 16);
         row_z    <= 48'd1 << (COEF_FRAC + 32);
         trans_xy <= '0;
         trans_z  <= '0;
         scales   <= '0;
         offsets  <= '0;
         aspect   <= 16'd21845;
         mismatch_count = 0;
         projected_q.delete();
      end else begin
         // Predict every accepted vertex
         if (req_tvalid && req_tready)
            projected_q.push_back(project_vertex(req_tdata, req_tlast));
         // Compare every accepted result with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got.screen_x = rsp_tdata[31:0];
            got.screen_y = rsp_tdata[63:32];
            got.depth    = rsp_tdata[95:64];
            got.fault    = rsp_tdata[96];
            got.last     = rsp_tlast;
            if (projected_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result beat: sx=%h sy=%h depth=%h fault=%b last=%b",
                           got.screen_x, got.screen_y, got.depth, got.fault, got.last);
            end else begin
               exp_p = projected_q.pop_front();
               if (got !== exp_p) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: expected %h %h %h %b %b, got %h %h %h %b %b",
                              exp_p.screen_x, exp_p.screen_y, exp_p.depth, exp_p.fault,
                              exp_p.last, got.screen_x, got.screen_y, got.depth,
                              got.fault, got.last);
               end
            end
         end
         // Track register writes
         if (csr_we) begin
            case (csr_addr)
               REG_ROW_X:    row_x    <= csr_wdata[47:0];
               REG_ROW_Y:    row_y    <= csr_wdata[47:0];
               REG_ROW_Z:    row_z    <= csr_wdata[47:0];
               REG_TRANS_XY: trans_xy <= csr_wdata;
               REG_TRANS_Z:  trans_z  <= csr_wdata[31:0];
               REG_SCALES:   scales   <= csr_wdata;
               REG_OFFSETS:  offsets  <= csr_wdata;
               REG_ASPECT:   aspect   <= csr_wdata[15:0];
               default: ;
            endcase
         end
      end
      pending_count = projected_q.size();
   end

endmodule

// ----- tb/vertex_transform_project_tb.sv -----
// Top of the vertex transform testbench: clock, reset, vertex and register stimulus,
// response back-pressure and the verdict. Depends on vtp_pkg, vtp_checker and the RTL.
`timescale 1ns / 1ps

module vertex_transform_project_tb;
   import vtp_pkg::*;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic [95:0]         req_tdata = '0;
   logic                req_tlast = 1'b0;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [103:0]        rsp_tdata;
   logic                rsp_tlast;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic                csr_we = 1'b0;
   logic [CSR_AW-1:0]   csr_addr = '0;
   logic [CSR_DW-1:0]   csr_wdata = '0;
   int                  mismatch_count;
   int                  pending_count;
   logic                ready_always = 1'b0;
   int                  stall_left = 0;

   localparam logic [31:0] MAX_POS = 32'h7FFF_FFFF;
   localparam logic [31:0] MAX_NEG = 32'h8000_0000;

   vertex_transform_project i_dut (
      .clock, .reset, .req_tdata, .req_tlast, .req_tvalid, .req_tready,
      .rsp_tdata, .rsp_tlast, .rsp_tvalid, .rsp_tready, .csr_we, .csr_addr, .csr_wdata
   );

   vtp_checker i_checker (
      .clock, .reset, .req_tdata, .req_tlast, .req_tvalid, .req_tready,
      .rsp_tdata, .rsp_tlast, .rsp_tvalid, .rsp_tready, .csr_we, .csr_addr, .csr_wdata,
      .mismatch_count, .pending_count
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5ms;
      $display("vertex_transform_project_tb: errors");
      $finish;
   end

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Response back-pressure: random stalls unless held always ready
   always @(posedge clock) begin
      if (ready_always) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         stall_left <= gap_length();
         rsp_tready <= 1'b1;
      end
   end

   task automatic write_reg(logic [CSR_AW-1:0] idx, logic [63:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic finish_writes();
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Hold a vertex beat until accepted; valid stays high for a back-to-back beat
   task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic lst);
      req_tvalid <= 1'b1;
      req_tdata  <= {z, y, x};
      req_tlast  <= lst;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic idle_sender(int n);
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic logic [31:0] small_coord();
      return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
   endfunction

   function automatic logic [31:0] pick_coord(int mode);
      case (mode) inside
         [0:3]:   return $urandom;
         [4:6]:   return small_coord();
         default: begin
            case ($urandom_range(0, 3))
               0: return MAX_POS;
               1: return MAX_NEG;
               2: return 32'hFFFF_FFFF;
               default: return 32'h0000_0000;
            endcase
         end
      endcase
   endfunction

   function automatic logic [15:0] small_coef();
      return 16'($urandom_range(0, 16'h8000) - 16'h4000);
   endfunction

   // Either fully random registers or a camera-like setup
   task automatic random_setup();
      logic tame;
      tame = 1'($urandom_range(0, 1));
      if (tame) begin
         write_reg(REG_ROW_X, {small_coef(), small_coef(), small_coef()});
         write_reg(REG_ROW_Y, {small_coef(), small_coef(), small_coef()});
         write_reg(REG_ROW_Z, {small_coef(), 32'd0});
         write_reg(REG_TRANS_XY, {small_coord(), small_coord()});
         write_reg(REG_TRANS_Z, $urandom_range(0, 1) ? 64'd0 : {32'd0, small_coord()});
         write_reg(REG_SCALES, {32'($urandom_range(1, 8)) << 16,
                                -(32'($urandom_range(1, 8)) << 16)});
         write_reg(REG_OFFSETS, {small_coord(), small_coord()});
         write_reg(REG_ASPECT, {48'd0, small_coef()});
      end else begin
         write_reg(REG_ROW_X, {$urandom, $urandom});
         write_reg(REG_ROW_Y, {$urandom, $urandom});
         write_reg(REG_ROW_Z, {$urandom, $urandom});
         write_reg(REG_TRANS_XY, {$urandom, $urandom});
         write_reg(REG_TRANS_Z, {$urandom, $urandom});
         write_reg(REG_SCALES, {$urandom, $urandom});
         write_reg(REG_OFFSETS, {$urandom, $urandom});
         write_reg(REG_ASPECT, {$urandom, $urandom});
      end
      finish_writes();
   endtask

   task automatic directed_set();
      send_vertex(32'd0, 32'd0, 32'd0, 1'b0);
      send_vertex(MAX_POS, MAX_POS, MAX_POS, 1'b0);
      send_vertex(MAX_NEG, MAX_NEG, MAX_NEG, 1'b0);
      send_vertex(MAX_POS, MAX_NEG, 32'hFFFF_FFFF, 1'b0);
      send_vertex(32'h0001_0000, 32'h0002_0000, MAX_NEG, 1'b0);
      send_vertex(32'h0003_0000, 32'hFFFD_0000, 32'hFFFF_0000, 1'b0);
      send_vertex(32'h0005_0000, 32'h0005_0000, 32'd0, 1'b1);
   endtask

   initial begin
      int items;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset registers: zero scale, so only offsets and depth show
      directed_set();
      drain();

      // Unit scales with offsets: plain perspective divide
      write_reg(REG_SCALES, {32'h0001_0000, 32'h0001_0000});
      write_reg(REG_OFFSETS, {32'h0010_0000, 32'hFFF0_0000});
      finish_writes();
      directed_set();
      drain();

      // Extreme registers: large and most negative values to exercise saturation
      write_reg(REG_ROW_X, 64'h7FFF_7FFF_7FFF);
      write_reg(REG_ROW_Y, 64'h8000_8000_8000);
      write_reg(REG_ROW_Z, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(REG_TRANS_XY, {MAX_NEG, MAX_POS});
      write_reg(REG_TRANS_Z, {32'hFFFF_FFFF, MAX_POS});
      write_reg(REG_SCALES, {MAX_NEG, MAX_POS});
      write_reg(REG_OFFSETS, {MAX_POS, MAX_NEG});
      write_reg(REG_ASPECT, 64'h8000);
      finish_writes();
      directed_set();
      drain();

      // Random phases with fresh registers each time
      items = 0;
      while (items < 650) begin
         int n;
         logic steady;
         random_setup();
         steady = ($urandom_range(0, 3) == 0);
         ready_always <= steady;
         n = $urandom_range(60, 120);
         if (n > 650 - items) n = 650 - items;
         repeat (n) begin
            int mode;
            mode = $urandom_range(0, 9);
            send_vertex(pick_coord(mode), pick_coord(mode),
                        (mode == 8) ? 32'd0 : pick_coord(mode),
                        ($urandom_range(0, 7) == 0));
            if (!steady) idle_sender(gap_length());
            items++;
         end
         drain();
      end

      ready_always <= 1'b0;
      drain();
      if (mismatch_count == 0 && pending_count == 0)
         $display("vertex_transform_project_tb: clean");
      else
         $display("vertex_transform_project_tb: errors");
      $finish;
   end

endmodule
